// ===== hdl/cor_pkg.sv =====
// ----------------------------------------------------------------------------
// cor_pkg: shared types and constants of the circle outline rasterizer
// Widths, state and command codes, and the controller/datapath interface.
// ----------------------------------------------------------------------------
package cor_pkg;

  localparam int MAX_RADIUS = 10;
  localparam int ARC_DEPTH  = 16;
  localparam int IDX_W      = $clog2(ARC_DEPTH);
  localparam int CNT_W      = IDX_W + 1;
  localparam int RAD_W      = 4;
  localparam int C_W        = 5;
  localparam int SQ_W       = 2 * C_W;
  localparam int CEN_W      = 15;
  localparam int PT_W       = 16;
  localparam int ENT_W      = 2 * C_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_GEN,
    ST_RUN_A,
    ST_RUN_B,
    ST_RUN_C,
    ST_RUN_D,
    ST_CENTER
  } state_e;

  typedef enum logic [2:0] {
    RD_HOLD,
    RD_ZERO,
    RD_ONE,
    RD_NM1,
    RD_NM2,
    RD_INC,
    RD_DEC
  } rd_op_e;

  typedef struct packed {
    logic   load;
    logic   gen_step;
    rd_op_e rd_op;
    logic   emit;
    logic   x_neg;
    logic   y_neg;
    logic   last;
    logic   center;
  } ctrl_cmd_t;

  typedef struct packed {
    logic rad_zero;
    logic gen_done;
    logic idx_eq_nm2;
    logic idx_eq_nm1;
    logic idx_zero;
    logic idx_one;
    logic n_is_two;
  } dp_status_t;

  function automatic logic [SQ_W-1:0] sq(input logic [C_W-1:0] a);
    return SQ_W'(a) * SQ_W'(a);
  endfunction

endpackage

// ===== hdl/cor_ctrl.sv =====
// ----------------------------------------------------------------------------
// cor_ctrl: sequencing controller
// Steps the arc generation, then walks the arc store in up to four runs (center only at radius 0).
// ----------------------------------------------------------------------------
module cor_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  start,
  output logic                  busy,
  input  cor_pkg::dp_status_t   status_i,
  output cor_pkg::ctrl_cmd_t    cmd_o
);

  cor_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= cor_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.rd_op = cor_pkg::RD_HOLD;
    unique case (state_q)
      cor_pkg::ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d = status_i.rad_zero ? cor_pkg::ST_CENTER : cor_pkg::ST_GEN;
        end
      end
      cor_pkg::ST_GEN: begin
        cmd_o.gen_step = 1'b1;
        if (status_i.gen_done) begin
          cmd_o.rd_op = cor_pkg::RD_ZERO;
          state_d = cor_pkg::ST_RUN_A;
        end
      end
      cor_pkg::ST_RUN_A: begin
        cmd_o.emit = 1'b1;
        if (status_i.idx_eq_nm2) begin
          cmd_o.rd_op = cor_pkg::RD_NM1;
          state_d = cor_pkg::ST_RUN_B;
        end else begin
          cmd_o.rd_op = cor_pkg::RD_INC;
        end
      end
      cor_pkg::ST_RUN_B: begin
        cmd_o.emit  = 1'b1;
        cmd_o.x_neg = 1'b1;
        if (status_i.idx_zero) begin
          cmd_o.rd_op = cor_pkg::RD_ONE;
          state_d = cor_pkg::ST_RUN_C;
        end else begin
          cmd_o.rd_op = cor_pkg::RD_DEC;
        end
      end
      cor_pkg::ST_RUN_C: begin
        cmd_o.emit  = 1'b1;
        cmd_o.x_neg = 1'b1;
        cmd_o.y_neg = 1'b1;
        if (status_i.idx_eq_nm1) begin
          if (status_i.n_is_two) begin
            cmd_o.last = 1'b1;
            state_d = cor_pkg::ST_IDLE;
          end else begin
            cmd_o.rd_op = cor_pkg::RD_NM2;
            state_d = cor_pkg::ST_RUN_D;
          end
        end else begin
          cmd_o.rd_op = cor_pkg::RD_INC;
        end
      end
      cor_pkg::ST_RUN_D: begin
        cmd_o.emit  = 1'b1;
        cmd_o.y_neg = 1'b1;
        if (status_i.idx_one) begin
          cmd_o.last = 1'b1;
          state_d = cor_pkg::ST_IDLE;
        end else begin
          cmd_o.rd_op = cor_pkg::RD_DEC;
        end
      end
      cor_pkg::ST_CENTER: begin
        cmd_o.emit   = 1'b1;
        cmd_o.center = 1'b1;
        cmd_o.last   = 1'b1;
        state_d = cor_pkg::ST_IDLE;
      end
      default: begin
        state_d = cor_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy = (state_q != cor_pkg::ST_IDLE);

`ifndef NO_ASSERTIONS
  a_last_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.last |=> state_q == cor_pkg::ST_IDLE)
    else $error("final point issued but controller did not return to idle");

  a_zero_center: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == cor_pkg::ST_IDLE && start && status_i.rad_zero)
      |=> state_q == cor_pkg::ST_CENTER)
    else $error("zero radius item did not take the center path");
`endif

endmodule

// ===== hdl/cor_datapath.sv =====
// ----------------------------------------------------------------------------
// cor_datapath: arc generation, arc store and point output pipeline
// Pushes one arc point per cycle and emits offset points from the registered
// read data through the output registers.
// ----------------------------------------------------------------------------
module cor_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic signed [cor_pkg::CEN_W-1:0]    center_x_i,
  input  logic signed [cor_pkg::CEN_W-1:0]    center_y_i,
  input  logic        [cor_pkg::RAD_W-1:0]    radius_i,
  input  cor_pkg::ctrl_cmd_t                  cmd_i,
  output cor_pkg::dp_status_t                 status_o,
  output logic                                point_valid_o,
  output logic signed [cor_pkg::PT_W-1:0]     point_x_o,
  output logic signed [cor_pkg::PT_W-1:0]     point_y_o,
  output logic                                last_point_o
);

  logic [cor_pkg::ENT_W-1:0] arc_mem [cor_pkg::ARC_DEPTH];

  logic signed [cor_pkg::CEN_W-1:0] cx_q, cy_q;
  logic [cor_pkg::RAD_W-1:0]        r_q, ax_q;
  logic [cor_pkg::C_W-1:0]          py_q;
  logic [cor_pkg::CNT_W-1:0]        cnt_q;
  logic [cor_pkg::IDX_W-1:0]        idx_q;

  logic [cor_pkg::RAD_W-1:0]        r_sat;
  logic [cor_pkg::C_W-1:0]          cand, cand1, y_new;
  logic [cor_pkg::SQ_W-1:0]         v;
  logic                             fits, more, advance;
  logic [cor_pkg::CNT_W-1:0]        n_m1, n_m2;
  logic                             we;
  logic [cor_pkg::IDX_W-1:0]        wa;
  logic [cor_pkg::ENT_W-1:0]        wd;

  logic [cor_pkg::ENT_W-1:0]        rd_q;
  logic                             s1_valid_q, s1_xneg_q, s1_yneg_q, s1_last_q, s1_center_q;

  logic signed [cor_pkg::PT_W-1:0]  ox, oy, px_d, py_out_d;
  logic                             valid_q, last_q;
  logic signed [cor_pkg::PT_W-1:0]  px_q, pyo_q;

  assign r_sat = (radius_i > cor_pkg::RAD_W'(cor_pkg::MAX_RADIUS))
                 ? cor_pkg::RAD_W'(cor_pkg::MAX_RADIUS) : radius_i;

  assign cand    = py_q + cor_pkg::C_W'(1);
  assign cand1   = py_q + cor_pkg::C_W'(2);
  assign v       = cor_pkg::sq({1'b0, r_q}) - cor_pkg::sq({1'b0, ax_q});
  assign fits    = (cor_pkg::sq(cand) <= v);
  assign more    = (cor_pkg::sq(cand1) <= v);
  assign y_new   = fits ? cand : py_q;
  assign advance = !fits || !more;

  assign n_m1 = cnt_q - cor_pkg::CNT_W'(1);
  assign n_m2 = cnt_q - cor_pkg::CNT_W'(2);

  assign status_o.rad_zero   = (radius_i == '0);
  assign status_o.gen_done   = advance && (ax_q == '0);
  assign status_o.idx_eq_nm2 = ({1'b0, idx_q} == n_m2);
  assign status_o.idx_eq_nm1 = ({1'b0, idx_q} == n_m1);
  assign status_o.idx_zero   = (idx_q == '0);
  assign status_o.idx_one    = (idx_q == cor_pkg::IDX_W'(1));
  assign status_o.n_is_two   = (cnt_q == cor_pkg::CNT_W'(2));

  always_comb begin
    we = 1'b0;
    wa = '0;
    wd = '0;
    if (cmd_i.load) begin
      we = 1'b1;
      wd = {1'b0, r_sat, cor_pkg::C_W'(0)};
    end else if (cmd_i.gen_step && cnt_q < cor_pkg::CNT_W'(cor_pkg::ARC_DEPTH)) begin
      we = 1'b1;
      wa = cnt_q[cor_pkg::IDX_W-1:0];
      wd = {1'b0, ax_q, y_new};
    end
  end

  always_ff @(posedge clk_i) begin
    if (we) begin
      arc_mem[wa] <= wd;
    end
    rd_q <= arc_mem[idx_q];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      cx_q <= center_x_i;
      cy_q <= center_y_i;
      r_q  <= r_sat;
      ax_q <= r_sat - cor_pkg::RAD_W'(1);
      py_q <= '0;
    end else if (cmd_i.gen_step) begin
      py_q <= y_new;
      if (advance) begin
        ax_q <= ax_q - cor_pkg::RAD_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      idx_q <= '0;
    end else begin
      if (cmd_i.load) begin
        cnt_q <= cor_pkg::CNT_W'(1);
      end else if (we) begin
        cnt_q <= cnt_q + cor_pkg::CNT_W'(1);
      end
      case (cmd_i.rd_op)
        cor_pkg::RD_ZERO: idx_q <= '0;
        cor_pkg::RD_ONE:  idx_q <= cor_pkg::IDX_W'(1);
        cor_pkg::RD_NM1:  idx_q <= n_m1[cor_pkg::IDX_W-1:0];
        cor_pkg::RD_NM2:  idx_q <= n_m2[cor_pkg::IDX_W-1:0];
        cor_pkg::RD_INC:  idx_q <= idx_q + cor_pkg::IDX_W'(1);
        cor_pkg::RD_DEC:  idx_q <= idx_q - cor_pkg::IDX_W'(1);
        default:          idx_q <= idx_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      valid_q    <= 1'b0;
    end else begin
      s1_valid_q <= cmd_i.emit;
      valid_q    <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s1_xneg_q   <= cmd_i.x_neg;
    s1_yneg_q   <= cmd_i.y_neg;
    s1_last_q   <= cmd_i.last;
    s1_center_q <= cmd_i.center;
  end

  always_comb begin
    ox = cor_pkg::PT_W'(rd_q[cor_pkg::ENT_W-1:cor_pkg::C_W]);
    oy = cor_pkg::PT_W'(rd_q[cor_pkg::C_W-1:0]);
    if (s1_center_q) begin
      ox = '0;
      oy = '0;
    end
    if (s1_xneg_q) begin
      ox = -ox;
    end
    if (s1_yneg_q) begin
      oy = -oy;
    end
    px_d     = {cx_q[cor_pkg::CEN_W-1], cx_q} + ox;
    py_out_d = {cy_q[cor_pkg::CEN_W-1], cy_q} + oy;
  end

  always_ff @(posedge clk_i) begin
    px_q   <= px_d;
    pyo_q  <= py_out_d;
    last_q <= s1_last_q;
  end

  assign point_valid_o = valid_q;
  assign point_x_o     = px_q;
  assign point_y_o     = pyo_q;
  assign last_point_o  = last_q;

`ifndef NO_ASSERTIONS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= cor_pkg::CNT_W'(cor_pkg::ARC_DEPTH))
    else $error("arc point count exceeds store depth");

  a_arc_rising: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.gen_step |=> py_q >= $past(py_q))
    else $error("arc row went down during generation");
`endif

endmodule

// ===== hdl/circle_outline_rasterizer_unit.sv =====
// ----------------------------------------------------------------------------
// circle_outline_rasterizer_unit: circle outline point generator
// Turns one circle item (center and radius) into its outline points.
// ----------------------------------------------------------------------------
// Usage: an item (center_x_i, center_y_i, radius_i) is taken at a rising edge
// where start is high and busy is low. Radii above 10 are treated as 10.
// The block first builds the upper-left arc into a 16-entry arc store, one
// arc point per cycle, with the row search stepping from the previous row.
// It then reads the store once per cycle and emits 4n-4 points, where n is
// the number of arc points (n is 15 at radius 10, so 56 points).
// Each point is on point_x_o/point_y_o for one cycle with point_valid_o high;
// the final point of the circle has last_point_o high. The receiver cannot
// stall the output, so there is no backpressure.
// Busy stays high from the accepting edge until the controller has issued
// the final point (a zero radius emits only the center). Points leave the
// read port through the read data register and the output registers; for a
// nonzero radius the first appears only after the arc store is built. The
// next item can be taken at the edge after busy falls. The single arc store
// read port sets one point per cycle.
// Reset clears the controller and counters; no item is in flight after it.
// ----------------------------------------------------------------------------
module circle_outline_rasterizer_unit (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [cor_pkg::CEN_W-1:0]    center_x_i,
  input  logic signed [cor_pkg::CEN_W-1:0]    center_y_i,
  input  logic        [cor_pkg::RAD_W-1:0]    radius_i,
  output logic                                point_valid_o,
  output logic signed [cor_pkg::PT_W-1:0]     point_x_o,
  output logic signed [cor_pkg::PT_W-1:0]     point_y_o,
  output logic                                last_point_o
);

  cor_pkg::ctrl_cmd_t  cmd;
  cor_pkg::dp_status_t status;

  cor_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .busy     (busy),
    .status_i (status),
    .cmd_o    (cmd)
  );

  cor_datapath u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .radius_i      (radius_i),
    .cmd_i         (cmd),
    .status_o      (status),
    .point_valid_o (point_valid_o),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .last_point_o  (last_point_o)
  );

endmodule

// ===== tb/circle_outline_rasterizer_unit_tb.sv =====
// ----------------------------------------------------------------------------
// circle_outline_rasterizer_unit_tb: self-checking bench for the rasterizer
// Sends circle items through the start/busy handshake, predicts every outline
// point from the center and radius, and checks each strobed point in order.
// ----------------------------------------------------------------------------
module circle_outline_rasterizer_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 200000;
  localparam int ARC_MAX     = 64;

  typedef struct packed {
    logic signed [cor_pkg::PT_W-1:0] x;
    logic signed [cor_pkg::PT_W-1:0] y;
    logic                            last;
  } outline_point_t;

  logic                             clk_i = 1'b0;
  logic                             rst_ni;
  logic                             start;
  logic                             busy;
  logic signed [cor_pkg::CEN_W-1:0] center_x_i;
  logic signed [cor_pkg::CEN_W-1:0] center_y_i;
  logic        [cor_pkg::RAD_W-1:0] radius_i;
  logic                             point_valid_o;
  logic signed [cor_pkg::PT_W-1:0]  point_x_o;
  logic signed [cor_pkg::PT_W-1:0]  point_y_o;
  logic                             last_point_o;

  outline_point_t outline_q[$];
  int             errors = 0;
  int             cycles = 0;
  int             idle_pct = 0;

  circle_outline_rasterizer_unit dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .start         (start),
    .busy          (busy),
    .center_x_i    (center_x_i),
    .center_y_i    (center_y_i),
    .radius_i      (radius_i),
    .point_valid_o (point_valid_o),
    .point_x_o     (point_x_o),
    .point_y_o     (point_y_o),
    .last_point_o  (last_point_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("circle_outline_rasterizer_unit_tb: done, errors");
      $finish;
    end
  end

  // Builds the upper-left arc, queues the 4n-4 outline points (one at radius 0).
  function automatic void predict_outline(input logic signed [cor_pkg::CEN_W-1:0] cx,
                                          input logic signed [cor_pkg::CEN_W-1:0] cy,
                                          input logic [cor_pkg::RAD_W-1:0] rad);
    int             arc_ax [ARC_MAX];
    int             arc_ay [ARC_MAX];
    int             r, g, n, m, total, x, y, prev_y, k, t, px, py, cxi, cyi;
    outline_point_t pt;
    cxi = cx;
    cyi = cy;
    r = (rad > cor_pkg::MAX_RADIUS) ? cor_pkg::MAX_RADIUS : int'(rad);
    if (r == 0) begin
      pt.x = cor_pkg::PT_W'(cxi);
      pt.y = cor_pkg::PT_W'(cyi);
      pt.last = 1'b1;
      outline_q = {outline_q, pt};
      return;
    end
    arc_ax[0] = r;
    arc_ay[0] = 0;
    g = 1;
    prev_y = 0;
    for (x = -r + 1; x <= 0; x++) begin
      y = 0;
      while ((y + 1) * (y + 1) <= r * r - x * x) y++;
      while (prev_y < y - 1) begin
        prev_y++;
        arc_ax[g] = -x;
        arc_ay[g] = prev_y;
        g++;
      end
      arc_ax[g] = -x;
      arc_ay[g] = y;
      g++;
      prev_y = y;
    end
    n = (g > cor_pkg::ARC_DEPTH) ? cor_pkg::ARC_DEPTH : g;
    m = 2 * n - 1;
    total = 2 * m - 2;
    for (k = 0; k < total; k++) begin
      t = (k < m) ? k : (m - 2) - (k - m);
      if (t < n - 1) begin
        px = arc_ax[t] & 31;
        py = arc_ay[t] & 31;
      end else begin
        px = -(arc_ax[2 * (n - 1) - t] & 31);
        py = arc_ay[2 * (n - 1) - t] & 31;
      end
      if (k >= m) py = -py;
      pt.x = cor_pkg::PT_W'(cxi + px);
      pt.y = cor_pkg::PT_W'(cyi + py);
      pt.last = (k == total - 1);
      outline_q = {outline_q, pt};
    end
  endfunction

  always @(posedge clk_i) begin
    outline_point_t want;
    if (rst_ni && point_valid_o) begin
      if (outline_q.size() == 0) begin
        $display("%0t: unexpected point x=%0d y=%0d last=%0b", $time,
                 point_x_o, point_y_o, last_point_o);
        errors++;
      end else begin
        want = outline_q.pop_front();
        if (point_x_o !== want.x) begin
          $display("%0t: point_x expected %0d, actual %0d", $time, want.x, point_x_o);
          errors++;
        end
        if (point_y_o !== want.y) begin
          $display("%0t: point_y expected %0d, actual %0d", $time, want.y, point_y_o);
          errors++;
        end
        if (last_point_o !== want.last) begin
          $display("%0t: last_point expected %0b, actual %0b", $time, want.last,
                   last_point_o);
          errors++;
        end
      end
    end
  end

  // Called at a falling edge. In each cycle the sender either idles or offers
  // the item; returns at the falling edge after the item is taken.
  task automatic send_circle(input logic signed [cor_pkg::CEN_W-1:0] cx,
                             input logic signed [cor_pkg::CEN_W-1:0] cy,
                             input logic [cor_pkg::RAD_W-1:0] rad);
    logic taken;
    taken = 1'b0;
    while (!taken) begin
      if ($urandom_range(99) < idle_pct) begin
        start      = 1'b0;
        center_x_i = cor_pkg::CEN_W'($urandom);
        center_y_i = cor_pkg::CEN_W'($urandom);
        radius_i   = cor_pkg::RAD_W'($urandom);
      end else begin
        start      = 1'b1;
        center_x_i = cx;
        center_y_i = cy;
        radius_i   = rad;
      end
      @(posedge clk_i);
      taken = start && !busy;
      @(negedge clk_i);
    end
    predict_outline(cx, cy, rad);
  endtask

  task automatic test_all_radii();
    for (int r = 0; r < (1 << cor_pkg::RAD_W); r++) begin
      send_circle(cor_pkg::CEN_W'(r * 37 - 200), cor_pkg::CEN_W'(100 - r * 51),
                  cor_pkg::RAD_W'(r));
    end
  endtask

  task automatic test_center_extremes();
    send_circle(15'sh3FFF, 15'sh3FFF, cor_pkg::RAD_W'(cor_pkg::MAX_RADIUS));
    send_circle(15'sh4000, 15'sh4000, cor_pkg::RAD_W'(cor_pkg::MAX_RADIUS));
    send_circle(15'sh3FFF, 15'sh4000, 4'hF);
    send_circle(15'sh4000, 15'sh3FFF, 4'd1);
    send_circle(15'sh4000, 15'sh4000, 4'd0);
    send_circle(15'sh3FFF, 15'sh3FFF, 4'd0);
  endtask

  task automatic test_random_circles(input int count, input int pct);
    logic signed [cor_pkg::CEN_W-1:0] cx, cy;
    logic        [cor_pkg::RAD_W-1:0] rad;
    int                               sel;
    idle_pct = pct;
    repeat (count) begin
      sel = $urandom_range(99);
      if (sel < 5) rad = '0;
      else if (sel < 12) rad = cor_pkg::RAD_W'($urandom_range(cor_pkg::MAX_RADIUS + 1,
                                                               (1 << cor_pkg::RAD_W) - 1));
      else rad = cor_pkg::RAD_W'($urandom_range(1, cor_pkg::MAX_RADIUS));
      cx = cor_pkg::CEN_W'($urandom);
      cy = cor_pkg::CEN_W'($urandom);
      if ($urandom_range(9) == 0) cx = $urandom_range(1) ? 15'sh3FFF : 15'sh4000;
      if ($urandom_range(9) == 0) cy = $urandom_range(1) ? 15'sh3FFF : 15'sh4000;
      send_circle(cx, cy, rad);
    end
  endtask

  initial begin
    rst_ni     = 1'b0;
    start      = 1'b0;
    center_x_i = '0;
    center_y_i = '0;
    radius_i   = '0;
    repeat (9) @(negedge clk_i);
    rst_ni = 1'b1;
    test_all_radii();
    test_center_extremes();
    test_random_circles(50, 0);
    test_random_circles(50, 51);
    test_random_circles(50, 0);
    test_random_circles(50, 15);
    start = 1'b0;
    while (outline_q.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("circle_outline_rasterizer_unit_tb: done, clean");
    end else begin
      $display("circle_outline_rasterizer_unit_tb: done, errors");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/cor_pkg.sv
hdl/cor_ctrl.sv
hdl/cor_datapath.sv
hdl/circle_outline_rasterizer_unit.sv
tb/circle_outline_rasterizer_unit_tb.sv
